[rtl/core/tetp_pkg.sv]
`timescale 1ns / 1ps

package tetp_pkg;

    // Slot count used when the top level is not given another.
    localparam int TETP_TASK_SLOTS = 8;

    // Field widths of the requests, results and registers.
    localparam int OPCODE_W   = 2;
    localparam int TASK_ID_W  = 8;
    localparam int STAMP_W    = 32;
    localparam int PERIOD_W   = 16;
    localparam int SUM_W      = 64;
    localparam int CPU_HZ_W   = 30;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Divider geometry: 32 quotient bits, divisor up to period times clock.
    localparam int QUO_W  = 32;
    localparam int QCNT_W = $clog2(QUO_W + 1);
    localparam int DVSR_W = PERIOD_W + CPU_HZ_W;

    // Intermediate widths of the query arithmetic.
    localparam int MHZ_W      = 11;
    localparam int AVG_DEN_W  = STAMP_W + MHZ_W;
    localparam int LOAD_NUM_W = 52;

    localparam logic [STAMP_W-1:0]    ONE_MILLION = 32'd1000000;
    localparam logic [CPU_HZ_W-1:0]   CPU_HZ_RESET = 30'd133000000;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_HZ  = 4'd1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_BEGIN = 2'd0,
        OP_END   = 2'd1,
        OP_QUERY = 2'd2,
        OP_CLEAR = 2'd3
    } tetp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_UPD,
        S_MHZ,
        S_MAXUS,
        S_AVG,
        S_AVGUS,
        S_LOAD,
        S_OUT
    } tetp_state_t;

    // One slot of the profiling table.
    typedef struct packed {
        logic [STAMP_W-1:0] start_stamp;
        logic [STAMP_W-1:0] worst_elapsed;
        logic [SUM_W-1:0]   elapsed_sum;
        logic [STAMP_W-1:0] sample_count;
    } tetp_row_t;

    // Control of the slot table.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } tetp_mem_ctl_t;

    // Request to the serial divider: dividend is {hi, lo}, hi below the divisor.
    typedef struct packed {
        logic               start;
        logic [STAMP_W-1:0] hi;
        logic [STAMP_W-1:0] lo;
        logic [DVSR_W-1:0]  dvsr;
    } tetp_div_req_t;

endpackage

[rtl/core/tetp_intf.sv]
`timescale 1ns / 1ps

// Request channel: one profiling command.
interface tetp_item_if import tetp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OPCODE_W-1:0]  opcode;
    logic [TASK_ID_W-1:0] task_id;
    logic [STAMP_W-1:0]   timestamp;
    logic [PERIOD_W-1:0]  task_period;

    modport source (output valid, opcode, task_id, timestamp, task_period, input ready);
    modport sink   (input valid, opcode, task_id, timestamp, task_period, output ready);
endinterface

// Result channel: the answer to one query.
interface tetp_result_if import tetp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               ok;
    logic [STAMP_W-1:0] worst_cyc;
    logic [STAMP_W-1:0] mean_cyc;
    logic [STAMP_W-1:0] sample_count;
    logic [STAMP_W-1:0] max_us;
    logic [STAMP_W-1:0] avg_us;
    logic [STAMP_W-1:0] load_ppt;

    modport source (output valid, ok, worst_cyc, mean_cyc, sample_count, max_us,
                    avg_us, load_ppt, input ready);
    modport sink   (input valid, ok, worst_cyc, mean_cyc, sample_count, max_us,
                    avg_us, load_ppt, output ready);
endinterface

// Configuration write channel.
interface tetp_cfg_if import tetp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/tetp_slot_mem.sv]
`timescale 1ns / 1ps

module tetp_slot_mem import tetp_pkg::*; #(
    parameter int  TASK_SLOTS = TETP_TASK_SLOTS,
    localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tetp_mem_ctl_t     ctl,
    input  logic [SLOT_W-1:0] rd_addr,
    input  logic [SLOT_W-1:0] wr_addr,
    input  tetp_row_t         wr_row,
    output tetp_row_t         rd_row
);

    tetp_row_t               mem [TASK_SLOTS];
    tetp_row_t               rd_data_reg;
    logic                    rd_valid_reg;
    logic [TASK_SLOTS-1:0]   valid_reg;

    // Table storage with a registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // One valid bit per slot; a slot never written since reset or clear reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clr)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

[rtl/core/tetp_div.sv]
`timescale 1ns / 1ps

module tetp_div import tetp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  tetp_div_req_t      req,
    output logic               done,
    output logic [QUO_W-1:0]   quo
);

    logic [DVSR_W-1:0] rem_reg;
    logic [DVSR_W-1:0] dvsr_reg;
    logic [QUO_W-1:0]  q_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic              sat_reg;

    logic [DVSR_W:0]   trial;
    logic [DVSR_W:0]   diff;
    logic              fits;
    logic [DVSR_W-1:0] rem_next;

    // One restoring step: bring down the next dividend bit and try the subtraction.
    always_comb
    begin
        trial    = {rem_reg, q_reg[QUO_W-1]};
        fits     = trial >= {1'b0, dvsr_reg};
        diff     = trial - {1'b0, dvsr_reg};
        rem_next = fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
    end

    // Step counter; every division takes the full number of steps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= QCNT_W'(QUO_W);
        end
        else if (run_reg)
        begin
            cnt_reg  <= cnt_reg - QCNT_W'(1);
            run_reg  <= (cnt_reg != QCNT_W'(1));
            done_reg <= (cnt_reg == QCNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Remainder and dividend/quotient shift register.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= DVSR_W'(req.hi);
            q_reg    <= req.lo;
            dvsr_reg <= req.dvsr;
            sat_reg  <= DVSR_W'(req.hi) >= req.dvsr;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[QUO_W-2:0], fits};
        end
    end

    // A quotient that cannot fit in 32 bits, or a zero divisor, reads as all ones.
    assign done = done_reg;
    assign quo  = sat_reg ? '1 : q_reg;

endmodule

[rtl/core/task_execution_time_profiler.sv]
`timescale 1ns / 1ps

// Per-task execution-time profiler over a table of task slots.
// The items channel takes begin, end, query and clear requests; only a query
// gives a result, on the results channel. The cfg channel writes the enable
// bit (index 0) and the counter clock in hertz (index 1); it is always ready,
// and the user is to write it only while the block is idle; the block
// itself does not enforce this. The block handles one request at a time
// and takes no new one while busy. A begin reads its slot, then writes the
// start stamp; an end reads its slot, then updates it; a clear, and a
// disabled or out-of-range begin or end, finish in the idle state. A query
// reads its slot, then runs five divisions one after another through a
// single radix-2 serial divider before its result goes out; an out-of-range
// query goes straight to the output step.
// Reset clears every slot at once (per-slot valid bits), disables profiling
// and sets the clock to 133 MHz. The result sits in an output register; while
// the receiver stalls, further requests that give no result are still taken,
// and a finished query waits for that register to empty.
module task_execution_time_profiler import tetp_pkg::*; #(
    parameter int TASK_SLOTS = TETP_TASK_SLOTS
) (
    input  logic          clk,
    input  logic          rst_n,
    tetp_item_if.sink     items,
    tetp_result_if.source results,
    tetp_cfg_if.sink      cfg
);

    localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    tetp_state_t            state_reg;
    tetp_state_t            state_next;

    logic                   enabled_reg;
    logic [CPU_HZ_W-1:0]    cpu_hz_reg;

    tetp_op_t               op_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [STAMP_W-1:0]     ts_reg;
    logic [PERIOD_W-1:0]    period_reg;
    logic                   qok_reg;
    logic [STAMP_W-1:0]     el_reg;

    logic [MHZ_W-1:0]       mhz_reg;
    logic [AVG_DEN_W-1:0]   den_reg;
    logic [LOAD_NUM_W-1:0]  num_reg;
    logic [2*STAMP_W-1:0]   prod_reg;
    logic [STAMP_W-1:0]     maxus_reg;
    logic [STAMP_W-1:0]     avg_reg;
    logic [STAMP_W-1:0]     avgus_reg;
    logic [STAMP_W-1:0]     load_reg;

    logic                   out_valid_reg;
    logic                   res_ok_reg;
    logic [STAMP_W-1:0]     res_max_reg;
    logic [STAMP_W-1:0]     res_avg_reg;
    logic [STAMP_W-1:0]     res_cnt_reg;
    logic [STAMP_W-1:0]     res_maxus_reg;
    logic [STAMP_W-1:0]     res_avgus_reg;
    logic [STAMP_W-1:0]     res_load_reg;

    logic                   item_acc;
    logic                   in_range;
    tetp_op_t               op_in;
    tetp_mem_ctl_t          mem_ctl;
    tetp_row_t              rd_row;
    tetp_row_t              wr_row;
    tetp_div_req_t          div_req;
    logic                   div_done;
    logic [QUO_W-1:0]       div_quo;
    logic [STAMP_W-1:0]     mul_a;
    logic [STAMP_W-1:0]     mul_b;
    logic                   out_load;
    logic                   ready;
    logic                   load_zero;

    assign op_in    = tetp_op_t'(items.opcode);
    assign in_range = 32'(items.task_id) < TASK_SLOTS;
    assign item_acc = items.valid && ready;
    assign items.ready = ready;
    assign load_zero = (period_reg == '0) || (rd_row.worst_elapsed == '0)
                       || (cpu_hz_reg == '0);

    tetp_slot_mem #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mem_ctl),
        .rd_addr (items.task_id[SLOT_W-1:0]),
        .wr_addr (slot_reg),
        .wr_row  (wr_row),
        .rd_row  (rd_row)
    );

    tetp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Configuration registers.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            cpu_hz_reg  <= CPU_HZ_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_ENABLED)
            begin
                enabled_reg <= cfg.data[0];
            end
            else if (cfg.index == CFG_CPU_HZ)
            begin
                cpu_hz_reg <= cfg.data[CPU_HZ_W-1:0];
            end
        end
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer: next state, table control, divider and multiplier operands.
    always_comb
    begin
        state_next = state_reg;
        ready      = 1'b0;
        mem_ctl    = '0;
        wr_row     = rd_row;
        div_req    = '0;
        mul_a      = '0;
        mul_b      = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                ready = 1'b1;
                if (items.valid)
                begin
                    unique case (op_in)
                        OP_BEGIN, OP_END:
                        begin
                            if (enabled_reg && in_range)
                            begin
                                mem_ctl.rd_en = 1'b1;
                                state_next    = S_READ;
                            end
                        end
                        OP_QUERY:
                        begin
                            mem_ctl.rd_en = in_range;
                            state_next    = in_range ? S_READ : S_OUT;
                        end
                        OP_CLEAR:
                        begin
                            mem_ctl.clr = enabled_reg;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                unique case (op_reg)
                    OP_BEGIN:
                    begin
                        mem_ctl.wr_en      = 1'b1;
                        wr_row.start_stamp = ts_reg;
                        state_next         = S_IDLE;
                    end
                    OP_END:
                    begin
                        state_next = S_UPD;
                    end
                    OP_QUERY:
                    begin
                        // Whole megahertz of the counter clock first.
                        div_req.start = 1'b1;
                        div_req.lo    = STAMP_W'(cpu_hz_reg);
                        div_req.dvsr  = DVSR_W'(ONE_MILLION);
                        state_next    = S_MHZ;
                    end
                    OP_CLEAR:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_UPD:
            begin
                mem_ctl.wr_en        = 1'b1;
                wr_row.worst_elapsed = (el_reg > rd_row.worst_elapsed) ? el_reg
                                       : rd_row.worst_elapsed;
                wr_row.elapsed_sum   = rd_row.elapsed_sum + SUM_W'(el_reg);
                wr_row.sample_count  = rd_row.sample_count + STAMP_W'(1);
                state_next           = S_IDLE;
            end
            S_MHZ:
            begin
                if (div_done)
                begin
                    div_req.start = 1'b1;
                    div_req.lo    = rd_row.worst_elapsed;
                    div_req.dvsr  = DVSR_W'(div_quo[MHZ_W-1:0]);
                    state_next    = S_MAXUS;
                end
            end
            S_MAXUS:
            begin
                // Samples times megahertz, the divisor of the average in microseconds.
                mul_a = rd_row.sample_count;
                mul_b = STAMP_W'(mhz_reg);
                if (div_done)
                begin
                    div_req.start = 1'b1;
                    div_req.hi    = rd_row.elapsed_sum[SUM_W-1:STAMP_W];
                    div_req.lo    = rd_row.elapsed_sum[STAMP_W-1:0];
                    div_req.dvsr  = DVSR_W'(rd_row.sample_count);
                    state_next    = S_AVG;
                end
            end
            S_AVG:
            begin
                mul_a = rd_row.worst_elapsed;
                mul_b = ONE_MILLION;
                if (div_done)
                begin
                    div_req.start = 1'b1;
                    div_req.hi    = rd_row.elapsed_sum[SUM_W-1:STAMP_W];
                    div_req.lo    = rd_row.elapsed_sum[STAMP_W-1:0];
                    div_req.dvsr  = DVSR_W'(den_reg);
                    state_next    = S_AVGUS;
                end
            end
            S_AVGUS:
            begin
                mul_a = STAMP_W'(period_reg);
                mul_b = STAMP_W'(cpu_hz_reg);
                if (div_done)
                begin
                    div_req.start = 1'b1;
                    div_req.hi    = STAMP_W'(num_reg[LOAD_NUM_W-1:STAMP_W]);
                    div_req.lo    = num_reg[STAMP_W-1:0];
                    div_req.dvsr  = prod_reg[DVSR_W-1:0];
                    state_next    = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Request capture, elapsed time and query intermediates.
    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            op_reg     <= op_in;
            slot_reg   <= items.task_id[SLOT_W-1:0];
            ts_reg     <= items.timestamp;
            period_reg <= items.task_period;
            qok_reg    <= in_range;
        end
        if (state_reg == S_READ)
        begin
            el_reg <= ts_reg - rd_row.start_stamp;
        end
        prod_reg <= mul_a * mul_b;
        if (div_done)
        begin
            unique case (state_reg)
                S_MHZ:   mhz_reg <= div_quo[MHZ_W-1:0];
                S_MAXUS:
                begin
                    maxus_reg <= div_quo;
                    den_reg   <= prod_reg[AVG_DEN_W-1:0];
                end
                S_AVG:
                begin
                    avg_reg <= div_quo;
                    num_reg <= prod_reg[LOAD_NUM_W-1:0];
                end
                S_AVGUS: avgus_reg <= div_quo;
                S_LOAD:  load_reg  <= div_quo;
                default: ;
            endcase
        end
    end

    // Output register; a failed query reports zero in every field.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_ok_reg    <= qok_reg;
            res_max_reg   <= qok_reg ? rd_row.worst_elapsed : '0;
            res_cnt_reg   <= qok_reg ? rd_row.sample_count : '0;
            res_maxus_reg <= qok_reg ? maxus_reg : '0;
            res_avg_reg   <= (qok_reg && rd_row.sample_count != '0) ? avg_reg : '0;
            res_avgus_reg <= (qok_reg && rd_row.sample_count != '0) ? avgus_reg : '0;
            res_load_reg  <= (qok_reg && !load_zero) ? load_reg : '0;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.ok           = res_ok_reg;
    assign results.worst_cyc    = res_max_reg;
    assign results.mean_cyc     = res_avg_reg;
    assign results.sample_count = res_cnt_reg;
    assign results.max_us       = res_maxus_reg;
    assign results.avg_us       = res_avgus_reg;
    assign results.load_ppt     = res_load_reg;

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_MHZ || state_reg == S_MAXUS || state_reg == S_AVG
                      || state_reg == S_AVGUS || state_reg == S_LOAD))
        else $error("divider finished outside a query step");

    // A table read is only ever issued for a request just taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> $past(items.valid && items.ready))
        else $error("table read state entered without a request");

    // A finished query always shows up on the result channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> results.valid)
        else $error("query result lost at the output register");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
    import tetp_pkg::*;

    localparam int          SLOTS        = TETP_TASK_SLOTS;
    localparam int          LIMIT        = 1000000;
    localparam int          QUIET_CYCLES = 200;
    localparam logic [63:0] USEC_PER_SEC = 64'd1000000;
    localparam logic [63:0] ALL_ONES32   = 64'h0000_0000_FFFF_FFFF;
    // Index that maps to no register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'hF;

    typedef struct packed {
        tetp_op_t             op;
        logic [TASK_ID_W-1:0] task_id;
        logic [STAMP_W-1:0]   stamp;
        logic [PERIOD_W-1:0]  period;
    } request_t;

    typedef struct packed {
        logic               ok;
        logic [STAMP_W-1:0] worst_cyc;
        logic [STAMP_W-1:0] mean_cyc;
        logic [STAMP_W-1:0] sample_count;
        logic [STAMP_W-1:0] max_us;
        logic [STAMP_W-1:0] avg_us;
        logic [STAMP_W-1:0] load_ppt;
    } report_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tetp_item_if   items_if ();
    tetp_result_if results_if ();
    tetp_cfg_if    cfg_if ();

    task_execution_time_profiler u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    // Predictor copy of the slot table and the registers.
    logic [STAMP_W-1:0]  mdl_start  [SLOTS];
    logic [STAMP_W-1:0]  mdl_worst  [SLOTS];
    logic [SUM_W-1:0]    mdl_sum    [SLOTS];
    logic [STAMP_W-1:0]  mdl_count  [SLOTS];
    logic                mdl_enabled;
    logic [CPU_HZ_W-1:0] mdl_cpu_hz;

    request_t pending_requests [$];
    report_t  expected_reports [$];

    request_t cur_request;
    int       send_gap;
    int       ready_gap;
    bit       steady;
    int       requests_queued;
    int       requests_taken;
    int       reports_checked;
    int       settings_applied;
    int       mismatches;
    int       cycles;

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(12, 60);
    endfunction

    function automatic logic [63:0] clamp32(input logic [63:0] v);
        return (v > ALL_ONES32) ? ALL_ONES32 : v;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < SLOTS; i++)
        begin
            mdl_start[i] = '0;
            mdl_worst[i] = '0;
            mdl_sum[i]   = '0;
            mdl_count[i] = '0;
        end
    endfunction

    // Works out the answer to a query from the current table and clock setting.
    function automatic report_t predict_report(input logic [TASK_ID_W-1:0] tid,
                                               input logic [PERIOD_W-1:0] period);
        report_t     rep;
        logic [63:0] mhz;
        logic [63:0] worst;
        logic [63:0] samples;
        logic [63:0] mean;
        logic [63:0] mean_us;
        logic [63:0] worst_us;
        logic [63:0] load;
        rep = '0;
        if (tid < SLOTS)
        begin
            worst   = {32'd0, mdl_worst[tid]};
            samples = {32'd0, mdl_count[tid]};
            mhz     = {34'd0, mdl_cpu_hz} / USEC_PER_SEC;
            mean    = '0;
            mean_us = '0;
            load    = '0;
            if (samples != 0)
            begin
                mean    = mdl_sum[tid] / samples;
                mean_us = (mhz != 0) ? clamp32(mean / mhz) : ALL_ONES32;
            end
            worst_us = (mhz != 0) ? (worst / mhz) : ALL_ONES32;
            if (period != 0 && worst != 0 && mdl_cpu_hz != 0)
                load = clamp32((worst * USEC_PER_SEC) /
                               ({48'd0, period} * {34'd0, mdl_cpu_hz}));
            mean             = clamp32(mean);
            rep.ok           = 1'b1;
            rep.worst_cyc    = worst[31:0];
            rep.mean_cyc     = mean[31:0];
            rep.sample_count = samples[31:0];
            rep.max_us       = worst_us[31:0];
            rep.avg_us       = mean_us[31:0];
            rep.load_ppt     = load[31:0];
        end
        return rep;
    endfunction

    // Applies one accepted request to the predicted table.
    function automatic void profile_apply(input request_t req);
        logic [STAMP_W-1:0] elapsed;
        int                 slot;
        bit                 live;
        slot = int'(req.task_id);
        live = mdl_enabled && (req.task_id < SLOTS);
        case (req.op)
            OP_BEGIN:
            begin
                if (live)
                    mdl_start[slot] = req.stamp;
            end
            OP_END:
            begin
                if (live)
                begin
                    elapsed = req.stamp - mdl_start[slot];
                    if (elapsed > mdl_worst[slot])
                        mdl_worst[slot] = elapsed;
                    mdl_sum[slot]   = mdl_sum[slot] + {32'd0, elapsed};
                    mdl_count[slot] = mdl_count[slot] + 32'd1;
                end
            end
            OP_CLEAR:
            begin
                if (mdl_enabled)
                    clear_table();
            end
            default:
                expected_reports.push_back(predict_report(req.task_id, req.period));
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got 0x%08h expected 0x%08h", field, got, want));
    endtask

    // Request driver: presents queued requests with random gaps between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_if.valid       <= 1'b0;
            items_if.opcode      <= OP_BEGIN;
            items_if.task_id     <= '0;
            items_if.timestamp   <= '0;
            items_if.task_period <= '0;
            send_gap = 0;
        end
        else
        begin
            if (items_if.valid && items_if.ready)
            begin
                profile_apply(cur_request);
                requests_taken++;
            end
            if (!items_if.valid || items_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    items_if.valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    cur_request           = pending_requests.pop_front();
                    items_if.valid       <= 1'b1;
                    items_if.opcode      <= cur_request.op;
                    items_if.task_id     <= cur_request.task_id;
                    items_if.timestamp   <= cur_request.stamp;
                    items_if.task_period <= cur_request.period;
                    send_gap = pick_gap();
                end
                else
                    items_if.valid <= 1'b0;
            end
        end
    end

    // Result monitor: random back-pressure and a field-by-field comparison.
    always @(posedge clk or negedge rst_n)
    begin
        report_t got;
        report_t want;
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
            ready_gap = 0;
        end
        else
        begin
            if (results_if.valid && results_if.ready)
            begin
                got.ok           = results_if.ok;
                got.worst_cyc    = results_if.worst_cyc;
                got.mean_cyc     = results_if.mean_cyc;
                got.sample_count = results_if.sample_count;
                got.max_us       = results_if.max_us;
                got.avg_us       = results_if.avg_us;
                got.load_ppt     = results_if.load_ppt;
                if (expected_reports.size() == 0)
                    flag_mismatch("result arrived with no query outstanding");
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("ok", {31'd0, got.ok}, {31'd0, want.ok});
                    check_field("worst_cyc", got.worst_cyc, want.worst_cyc);
                    check_field("mean_cyc", got.mean_cyc, want.mean_cyc);
                    check_field("sample_count", got.sample_count, want.sample_count);
                    check_field("max_us", got.max_us, want.max_us);
                    check_field("avg_us", got.avg_us, want.avg_us);
                    check_field("load_ppt", got.load_ppt, want.load_ppt);
                    reports_checked++;
                end
            end
            if (ready_gap > 0)
            begin
                ready_gap--;
                results_if.ready <= 1'b0;
            end
            else
            begin
                results_if.ready <= 1'b1;
                ready_gap = pick_gap();
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycles, expected_reports.size());
            $display("task_execution_time_profiler verification failed");
            $finish;
        end
    end

    task automatic queue_request(input tetp_op_t op, input logic [TASK_ID_W-1:0] tid,
                                 input logic [STAMP_W-1:0] stamp,
                                 input logic [PERIOD_W-1:0] period);
        request_t req;
        req.op      = op;
        req.task_id = tid;
        req.stamp   = stamp;
        req.period  = period;
        pending_requests.push_back(req);
        requests_queued++;
    endtask

    // Waits until every request is taken and every result is back, then lets
    // the block finish any request that gives no result.
    task automatic settle();
        while (requests_taken != requests_queued || expected_reports.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        if (idx == CFG_ENABLED)
            mdl_enabled = value[0];
        else if (idx == CFG_CPU_HZ)
            mdl_cpu_hz = value[CPU_HZ_W-1:0];
        settings_applied++;
    endtask

    function automatic logic [STAMP_W-1:0] pick_span();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom_range(0, 5000);
        if (r < 7)
            return $urandom_range(0, 32'h00FF_FFFF);
        if (r < 9)
            return $urandom;
        return ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
    endfunction

    function automatic logic [PERIOD_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 5)
            return PERIOD_W'($urandom_range(1, 100));
        return PERIOD_W'($urandom);
    endfunction

    // Mostly well-formed begin/end pairs followed by a query of the same task,
    // with a share of loose requests of any kind in between.
    task automatic fill_random(input int total);
        int                 made;
        int                 reps;
        logic [7:0]         tid;
        logic [STAMP_W-1:0] stamp;
        tetp_op_t           op;
        made = 0;
        while (made < total)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                tid  = TASK_ID_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                             : $urandom_range(0, SLOTS - 1));
                reps = $urandom_range(1, 3);
                for (int k = 0; k < reps; k++)
                begin
                    stamp = $urandom;
                    queue_request(OP_BEGIN, tid, stamp, PERIOD_W'($urandom));
                    queue_request(OP_END, tid, stamp + pick_span(), PERIOD_W'($urandom));
                    made += 2;
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    queue_request(OP_QUERY, tid, $urandom, pick_period());
                    made++;
                end
            end
            else
            begin
                op = tetp_op_t'($urandom_range(0, 3));
                // Clears wipe the table, so only a few are let through.
                if (op == OP_CLEAR && $urandom_range(0, 9) != 0)
                    op = OP_QUERY;
                tid = TASK_ID_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 255)
                                                            : $urandom_range(0, SLOTS - 1));
                queue_request(op, tid, $urandom, pick_period());
                made++;
            end
        end
    endtask

    initial
    begin
        logic [CPU_HZ_W-1:0] hz_plan [9];
        bit                  en_plan [9];
        int                  size_plan [9];
        logic [CFG_DATA_W-1:0] word;

        cfg_if.valid       = 1'b0;
        cfg_if.index       = CFG_ENABLED;
        cfg_if.data        = '0;
        clear_table();
        mdl_enabled      = 1'b0;
        mdl_cpu_hz       = CPU_HZ_RESET;
        steady           = 1'b0;
        requests_queued  = 0;
        requests_taken   = 0;
        reports_checked  = 0;
        settings_applied = 0;
        mismatches       = 0;
        cycles           = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Profiling is off after reset: begin, end and clear leave the table alone.
        queue_request(OP_BEGIN, 8'd0, 32'd100, 16'd0);
        queue_request(OP_END, 8'd0, 32'd500, 16'd0);
        queue_request(OP_CLEAR, 8'd0, 32'd0, 16'd0);
        queue_request(OP_QUERY, 8'd0, 32'd0, 16'd10);
        queue_request(OP_QUERY, 8'd255, 32'hFFFF_FFFF, 16'hFFFF);
        settle();

        write_register(CFG_UNUSED, $urandom);
        write_register(CFG_ENABLED, 32'd1);

        // Wrapped timestamps, the largest and the smallest elapsed time, the
        // extreme periods, out-of-range tasks and a clear.
        queue_request(OP_BEGIN, 8'd0, 32'hFFFF_FFF0, 16'd0);
        queue_request(OP_END, 8'd0, 32'h0000_0010, 16'd0);
        queue_request(OP_BEGIN, 8'd7, 32'd0, 16'd0);
        queue_request(OP_END, 8'd7, 32'hFFFF_FFFF, 16'd0);
        queue_request(OP_QUERY, 8'd7, 32'd0, 16'd1);
        queue_request(OP_QUERY, 8'd7, 32'd0, 16'hFFFF);
        queue_request(OP_QUERY, 8'd0, 32'd0, 16'd0);
        queue_request(OP_BEGIN, 8'd8, 32'd5, 16'd0);
        queue_request(OP_END, 8'd8, 32'd50, 16'd0);
        queue_request(OP_QUERY, 8'd8, 32'd0, 16'd20);
        queue_request(OP_BEGIN, 8'd3, 32'h1234_5678, 16'd0);
        queue_request(OP_END, 8'd3, 32'h1234_5678, 16'd0);
        queue_request(OP_QUERY, 8'd3, 32'd0, 16'd1000);
        queue_request(OP_CLEAR, 8'd0, 32'd0, 16'd0);
        queue_request(OP_QUERY, 8'd7, 32'd0, 16'd1);
        queue_request(OP_QUERY, 8'd255, 32'd0, 16'hFFFF);
        settle();

        // Clock settings for the random part: the range ends, a clock below
        // one MHz, a zero clock, a tiny clock that saturates the load, and the
        // largest value the register holds. One short stretch runs disabled.
        hz_plan[0] = 30'd1000000;     en_plan[0] = 1'b1; size_plan[0] = 100;
        hz_plan[1] = 30'd1000000000;  en_plan[1] = 1'b1; size_plan[1] = 100;
        hz_plan[2] = CPU_HZ_W'($urandom_range(1000000, 1000000000));
        en_plan[2] = 1'b1;            size_plan[2] = 100;
        hz_plan[3] = 30'd999999;      en_plan[3] = 1'b1; size_plan[3] = 100;
        hz_plan[4] = CPU_HZ_RESET;    en_plan[4] = 1'b0; size_plan[4] = 40;
        hz_plan[5] = 30'd0;           en_plan[5] = 1'b1; size_plan[5] = 100;
        hz_plan[6] = 30'd1;           en_plan[6] = 1'b1; size_plan[6] = 100;
        hz_plan[7] = 30'h3FFF_FFFF;   en_plan[7] = 1'b1; size_plan[7] = 100;
        hz_plan[8] = CPU_HZ_W'($urandom_range(1000000, 1000000000));
        en_plan[8] = 1'b1;            size_plan[8] = 100;

        for (int p = 0; p < 9; p++)
        begin
            // Spare data bits carry random values; only the low bits count.
            word = $urandom;
            word[0] = en_plan[p];
            write_register(CFG_ENABLED, word);
            word = $urandom;
            word[CPU_HZ_W-1:0] = hz_plan[p];
            write_register(CFG_CPU_HZ, word);
            steady = (p == 2 || p == 6);
            fill_random(size_plan[p]);
            settle();
        end

        steady = 1'b0;
        if (expected_reports.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_reports.size()));

        $display("Sent %0d requests and checked %0d query results across %0d register writes.",
                 requests_taken, reports_checked, settings_applied);
        $display("Clocks from zero to the register maximum, with profiling on and off.");
        if (mismatches == 0)
            $display("task_execution_time_profiler verification clean");
        else
            $display("task_execution_time_profiler verification failed");
        $finish;
    end

endmodule
